// File: sv/hrc_pkg.sv
package hrc_pkg;

	// Hue arrives in whole degrees on a 9-bit field
	localparam int HUE_W = 9;
	// Secondary weight 60 - |hue mod 120 - 60| spans 0..60
	localparam int WT_W  = 6;
	localparam int MOD_W = 7;

	localparam logic [HUE_W-1:0] DEG_60  = HUE_W'(60);
	localparam logic [HUE_W-1:0] DEG_120 = HUE_W'(120);
	localparam logic [HUE_W-1:0] DEG_180 = HUE_W'(180);
	localparam logic [HUE_W-1:0] DEG_240 = HUE_W'(240);
	localparam logic [HUE_W-1:0] DEG_300 = HUE_W'(300);
	localparam logic [HUE_W-1:0] DEG_360 = HUE_W'(360);
	localparam logic [HUE_W-1:0] DEG_480 = HUE_W'(480);

	// Sixty-degree hue sectors; hue beyond 359 lands in the magenta-red one
	typedef enum logic [2:0] {
		SEC_RED_YEL,
		SEC_YEL_GRN,
		SEC_GRN_CYN,
		SEC_CYN_BLU,
		SEC_BLU_MAG,
		SEC_MAG_RED
	} sector_t;

	typedef struct packed {
		sector_t           sector;
		logic [WT_W-1:0]   weight;
	} hue_class_t;

endpackage

// File: sv/hsv_to_rgb_converter.sv
// HSV to RGB converter. Each beat on the pixel channel carries hue in whole
// degrees (0..359; larger codes fall in the magenta-red sector) with saturation
// and brightness as CHANNEL_BITS-bit fractions of full scale, and yields one
// beat of red, green and blue on the result channel, in order. Sustained rate
// is one pixel per clock while no result beat is held. Each accepted pixel passes
// through one front register that works out the hue
// sector and secondary weight, a two-slot queue, then a five-stage back end
// (saturation times brightness, exact divide by full scale, times the weight,
// reciprocal divide by sixty, sector mux plus offset into the output register).
// The back end freezes as a whole while its output beat is held; the queue
// lets the front keep taking pixels meanwhile until both its slots are full.
module hsv_to_rgb_converter #(
	parameter int CHANNEL_BITS = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              pix_valid,
	output logic                              pix_ready,
	input  logic [hrc_pkg::HUE_W-1:0]         hue,
	input  logic [CHANNEL_BITS-1:0]           saturation,
	input  logic [CHANNEL_BITS-1:0]           brightness,
	output logic                              rgb_valid,
	input  logic                              rgb_ready,
	output logic [CHANNEL_BITS-1:0]           red,
	output logic [CHANNEL_BITS-1:0]           green,
	output logic [CHANNEL_BITS-1:0]           blue
);

	localparam int CW = $bits(hrc_pkg::hue_class_t);
	localparam int DW = CW + 2 * CHANNEL_BITS;

	// Front to queue
	logic                        f_valid;
	logic                        f_ready;
	hrc_pkg::hue_class_t         f_cls;
	logic [CHANNEL_BITS-1:0]     f_sat;
	logic [CHANNEL_BITS-1:0]     f_val;

	// Queue to back end
	logic                        b_valid;
	logic                        b_ready;
	logic [DW-1:0]               b_data;
	hrc_pkg::hue_class_t         b_cls;
	logic [CHANNEL_BITS-1:0]     b_sat;
	logic [CHANNEL_BITS-1:0]     b_val;

	hrc_front #(
		.CHANNEL_BITS(CHANNEL_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.pix_valid  (pix_valid),
		.pix_ready  (pix_ready),
		.hue        (hue),
		.saturation (saturation),
		.brightness (brightness),
		.cls_valid  (f_valid),
		.cls_ready  (f_ready),
		.cls        (f_cls),
		.cls_sat    (f_sat),
		.cls_val    (f_val)
	);

	hrc_queue #(
		.WIDTH(DW)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_data  ({f_cls, f_sat, f_val}),
		.pop_valid  (b_valid),
		.pop_ready  (b_ready),
		.pop_data   (b_data)
	);

	// Unpack the queued beat
	assign b_cls = hrc_pkg::hue_class_t'(b_data[DW-1 -: CW]);
	assign b_sat = b_data[CHANNEL_BITS +: CHANNEL_BITS];
	assign b_val = b_data[CHANNEL_BITS-1:0];

	hrc_back #(
		.CHANNEL_BITS(CHANNEL_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cls_valid  (b_valid),
		.cls_ready  (b_ready),
		.cls        (b_cls),
		.cls_sat    (b_sat),
		.cls_val    (b_val),
		.rgb_valid  (rgb_valid),
		.rgb_ready  (rgb_ready),
		.red        (red),
		.green      (green),
		.blue       (blue)
	);

endmodule

// File: sv/hrc_front.sv
module hrc_front #(
	parameter int CHANNEL_BITS = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                pix_valid,
	output logic                                pix_ready,
	input  logic [hrc_pkg::HUE_W-1:0]           hue,
	input  logic [CHANNEL_BITS-1:0]             saturation,
	input  logic [CHANNEL_BITS-1:0]             brightness,
	output logic                                cls_valid,
	input  logic                                cls_ready,
	output hrc_pkg::hue_class_t                 cls,
	output logic [CHANNEL_BITS-1:0]             cls_sat,
	output logic [CHANNEL_BITS-1:0]             cls_val
);

	logic                          vld_q;
	hrc_pkg::hue_class_t           cls_q;
	logic [CHANNEL_BITS-1:0]       sat_q;
	logic [CHANNEL_BITS-1:0]       val_q;
	logic [hrc_pkg::HUE_W-1:0]     hue_mod;
	logic [hrc_pkg::MOD_W-1:0]     mod_n;
	hrc_pkg::hue_class_t           cls_d;
	logic                          take;

	// Fold hue into 0..119, then weight rises to 60 and falls back
	always_comb begin
		if (hue < hrc_pkg::DEG_120) begin
			hue_mod = hue;
		end else if (hue < hrc_pkg::DEG_240) begin
			hue_mod = hue - hrc_pkg::DEG_120;
		end else if (hue < hrc_pkg::DEG_360) begin
			hue_mod = hue - hrc_pkg::DEG_240;
		end else if (hue < hrc_pkg::DEG_480) begin
			hue_mod = hue - hrc_pkg::DEG_360;
		end else begin
			hue_mod = hue - hrc_pkg::DEG_480;
		end
		mod_n = hue_mod[hrc_pkg::MOD_W-1:0];
		if (hue_mod < hrc_pkg::DEG_60) begin
			cls_d.weight = mod_n[hrc_pkg::WT_W-1:0];
		end else begin
			cls_d.weight = hrc_pkg::WT_W'(hrc_pkg::DEG_120[hrc_pkg::MOD_W-1:0] - mod_n);
		end

		if (hue < hrc_pkg::DEG_60) begin
			cls_d.sector = hrc_pkg::SEC_RED_YEL;
		end else if (hue < hrc_pkg::DEG_120) begin
			cls_d.sector = hrc_pkg::SEC_YEL_GRN;
		end else if (hue < hrc_pkg::DEG_180) begin
			cls_d.sector = hrc_pkg::SEC_GRN_CYN;
		end else if (hue < hrc_pkg::DEG_240) begin
			cls_d.sector = hrc_pkg::SEC_CYN_BLU;
		end else if (hue < hrc_pkg::DEG_300) begin
			cls_d.sector = hrc_pkg::SEC_BLU_MAG;
		end else begin
			cls_d.sector = hrc_pkg::SEC_MAG_RED;
		end
	end

	assign pix_ready = !vld_q || cls_ready;
	assign take      = pix_valid && pix_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (pix_ready) begin
			vld_q <= pix_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cls_q <= cls_d;
			sat_q <= saturation;
			val_q <= brightness;
		end
	end

	assign cls_valid = vld_q;
	assign cls       = cls_q;
	assign cls_sat   = sat_q;
	assign cls_val   = val_q;

endmodule

// File: sv/hrc_queue.sv
module hrc_queue #(
	parameter int WIDTH = 22
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  logic [WIDTH-1:0] push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output logic [WIDTH-1:0] pop_data
);

	// Two slots: head is always the oldest beat
	logic [1:0]       cnt_q;
	logic [WIDTH-1:0] head_q;
	logic [WIDTH-1:0] tail_q;
	logic             push;
	logic             pop;

	assign push_ready = (cnt_q != 2'd2);
	assign pop_valid  = (cnt_q != 2'd0);
	assign pop_data   = head_q;
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (push && !pop) begin
			cnt_q <= cnt_q + 2'd1;
		end else if (pop && !push) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		case (cnt_q)
			2'd0: begin
				if (push) begin
					head_q <= push_data;
				end
			end
			2'd1: begin
				if (push && pop) begin
					head_q <= push_data;
				end else if (push) begin
					tail_q <= push_data;
				end
			end
			default: begin
				if (pop) begin
					head_q <= tail_q;
				end
				if (push) begin
					tail_q <= push_data;
				end
			end
		endcase
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("queue fill count out of range");

	assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd1) && pop && !push |=> (cnt_q == 2'd0))
		else $error("queue failed to drain its last beat");

	assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd2) && !pop |=> $stable(head_q))
		else $error("queue head moved without a pop");

endmodule

// File: sv/hrc_back.sv
module hrc_back #(
	parameter int CHANNEL_BITS = 8
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cls_valid,
	output logic                      cls_ready,
	input  hrc_pkg::hue_class_t       cls,
	input  logic [CHANNEL_BITS-1:0]   cls_sat,
	input  logic [CHANNEL_BITS-1:0]   cls_val,
	output logic                      rgb_valid,
	input  logic                      rgb_ready,
	output logic [CHANNEL_BITS-1:0]   red,
	output logic [CHANNEL_BITS-1:0]   green,
	output logic [CHANNEL_BITS-1:0]   blue
);

	localparam int N    = CHANNEL_BITS;
	localparam int PW   = 2 * N;
	localparam int XW   = N + hrc_pkg::WT_W;
	// Divide by 60 as a multiply by ceil(2^K / 60); exact for XW-bit dividends
	localparam int K    = XW + 6;
	localparam longint unsigned RECIP = ((64'd1 << K) + 64'd59) / 64'd60;
	localparam int MW   = K - 5;
	localparam int QW   = XW + MW;
	localparam logic [N-1:0] FULL = {N{1'b1}};

	logic                     adv;
	logic                     vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;

	logic [PW-1:0]            prod_s1;
	logic [N-1:0]             val_s1;
	hrc_pkg::sector_t         sec_s1, sec_s2, sec_s3, sec_s4;
	logic [hrc_pkg::WT_W-1:0] wt_s1, wt_s2;

	logic [N-1:0]             chroma_s2, chroma_s3, chroma_s4;
	logic [N-1:0]             off_s2, off_s3, off_s4;
	logic [XW-1:0]            xprod_s3;
	logic [QW-1:0]            quot_s4;

	logic [PW:0]              div_sum;
	logic [N-1:0]             chroma_d;
	logic [N-1:0]             sec_x;
	logic [N-1:0]             r_d, g_d, b_d;
	logic [N-1:0]             red_s5, green_s5, blue_s5;

	// Whole pipe advances unless the output beat is held
	assign adv       = !vld_s5 || rgb_ready;
	assign cls_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= cls_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	// Divide by 2^N-1 exactly for products of two N-bit values
	assign div_sum  = {1'b0, prod_s1} + (PW+1)'(prod_s1 >> N) + (PW+1)'(1);
	assign chroma_d = div_sum[N +: N];
	assign sec_x    = quot_s4[K +: N];

	always_comb begin
		r_d = '0;
		g_d = '0;
		b_d = '0;
		unique case (sec_s4)
			hrc_pkg::SEC_RED_YEL: begin r_d = chroma_s4; g_d = sec_x; end
			hrc_pkg::SEC_YEL_GRN: begin r_d = sec_x; g_d = chroma_s4; end
			hrc_pkg::SEC_GRN_CYN: begin g_d = chroma_s4; b_d = sec_x; end
			hrc_pkg::SEC_CYN_BLU: begin g_d = sec_x; b_d = chroma_s4; end
			hrc_pkg::SEC_BLU_MAG: begin r_d = sec_x; b_d = chroma_s4; end
			hrc_pkg::SEC_MAG_RED: begin r_d = chroma_s4; b_d = sec_x; end
			default: begin end
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s1   <= PW'(cls_sat) * PW'(cls_val);
			val_s1    <= cls_val;
			sec_s1    <= cls.sector;
			wt_s1     <= cls.weight;

			chroma_s2 <= chroma_d;
			off_s2    <= val_s1 - chroma_d;
			sec_s2    <= sec_s1;
			wt_s2     <= wt_s1;

			xprod_s3  <= XW'(chroma_s2) * XW'(wt_s2);
			chroma_s3 <= chroma_s2;
			off_s3    <= off_s2;
			sec_s3    <= sec_s2;

			quot_s4   <= QW'(xprod_s3) * QW'(RECIP);
			chroma_s4 <= chroma_s3;
			off_s4    <= off_s3;
			sec_s4    <= sec_s3;

			red_s5    <= r_d + off_s4;
			green_s5  <= g_d + off_s4;
			blue_s5   <= b_d + off_s4;
		end
	end

	assign rgb_valid = vld_s5;
	assign red       = red_s5;
	assign green     = green_s5;
	assign blue      = blue_s5;

	assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 |-> ({1'b0, chroma_s2} + {1'b0, off_s2}) <= {1'b0, FULL})
		else $error("chroma plus offset exceeds full scale");

	assert property (@(posedge clk) disable iff (!arst_n)
		vld_s3 |-> xprod_s3 <= XW'(chroma_s3) * XW'(hrc_pkg::DEG_60))
		else $error("secondary product above chroma times sixty");

	assert property (@(posedge clk) disable iff (!arst_n)
		vld_s4 |-> sec_x <= chroma_s4)
		else $error("secondary component exceeds chroma");

endmodule

// File: sim/tb_hsv_to_rgb_converter.sv
module tb_hsv_to_rgb_converter;

	localparam int CB              = 8;
	localparam int FULL            = (1 << CB) - 1;
	localparam int N_DIRECTED      = 23;
	localparam int N_RANDOM        = 1100;
	localparam int N_TOTAL         = N_DIRECTED + N_RANDOM;
	// Generous tail for stray beats once every owed colour is back
	localparam int DRAIN_CYCLES    = 20;
	localparam int HOLD_OFF_CYCLES = 300;
	// Longest quiet stretch in a good run is the hold-off above
	localparam int STALL_LIMIT     = 2000;
	localparam int MAX_PRINTED     = 50;

	typedef struct packed {
		logic [CB-1:0] red;
		logic [CB-1:0] green;
		logic [CB-1:0] blue;
	} rgb_t;

	// One directed pixel; where known is set the colour is typed in by hand,
	// otherwise the beat is checked against convert_hsv
	typedef struct packed {
		logic [hrc_pkg::HUE_W-1:0] hue;
		logic [CB-1:0]             sat;
		logic [CB-1:0]             bri;
		logic                      known;
		logic [CB-1:0]             red;
		logic [CB-1:0]             green;
		logic [CB-1:0]             blue;
	} pix_row_t;

	localparam pix_row_t DIRECTED_ROWS [0:N_DIRECTED-1] = '{
		// black, and zero brightness at full saturation
		'{9'd0,   8'd0,   8'd0,   1'b1, 8'd0,   8'd0,   8'd0},
		'{9'd359, 8'd255, 8'd0,   1'b1, 8'd0,   8'd0,   8'd0},
		// no saturation gives grey at the brightness level
		'{9'd200, 8'd0,   8'd255, 1'b1, 8'd255, 8'd255, 8'd255},
		// the six primaries and secondaries on the sector bounds
		'{9'd0,   8'd255, 8'd255, 1'b1, 8'd255, 8'd0,   8'd0},
		'{9'd60,  8'd255, 8'd255, 1'b1, 8'd255, 8'd255, 8'd0},
		'{9'd120, 8'd255, 8'd255, 1'b1, 8'd0,   8'd255, 8'd0},
		'{9'd180, 8'd255, 8'd255, 1'b1, 8'd0,   8'd255, 8'd255},
		'{9'd240, 8'd255, 8'd255, 1'b1, 8'd0,   8'd0,   8'd255},
		'{9'd300, 8'd255, 8'd255, 1'b1, 8'd255, 8'd0,   8'd255},
		// one degree short of each bound
		'{9'd59,  8'd255, 8'd255, 1'b0, 8'd0,   8'd0,   8'd0},
		'{9'd119, 8'd255, 8'd255, 1'b0, 8'd0,   8'd0,   8'd0},
		'{9'd179, 8'd255, 8'd255, 1'b0, 8'd0,   8'd0,   8'd0},
		'{9'd239, 8'd255, 8'd255, 1'b0, 8'd0,   8'd0,   8'd0},
		'{9'd299, 8'd255, 8'd255, 1'b0, 8'd0,   8'd0,   8'd0},
		'{9'd359, 8'd255, 8'd255, 1'b0, 8'd0,   8'd0,   8'd0},
		// hue past 359 lands in the magenta-red sector, weight from hue mod 120
		'{9'd360, 8'd255, 8'd255, 1'b1, 8'd255, 8'd0,   8'd0},
		'{9'd480, 8'd255, 8'd255, 1'b1, 8'd255, 8'd0,   8'd0},
		'{9'd511, 8'd255, 8'd255, 1'b0, 8'd0,   8'd0,   8'd0},
		'{9'd420, 8'd255, 8'd255, 1'b0, 8'd0,   8'd0,   8'd0},
		// truncating divides at awkward fractions
		'{9'd30,  8'd128, 8'd200, 1'b0, 8'd0,   8'd0,   8'd0},
		'{9'd90,  8'd255, 8'd1,   1'b0, 8'd0,   8'd0,   8'd0},
		'{9'd0,   8'd1,   8'd255, 1'b0, 8'd0,   8'd0,   8'd0},
		'{9'd256, 8'd170, 8'd85,  1'b0, 8'd0,   8'd0,   8'd0}
	};

	logic                         clk        = 1'b0;
	logic                         arst_n     = 1'b0;
	logic                         pix_valid  = 1'b0;
	logic [hrc_pkg::HUE_W-1:0]    hue        = '0;
	logic [CB-1:0]                saturation = '0;
	logic [CB-1:0]                brightness = '0;
	logic                         rgb_ready  = 1'b0;
	logic                         pix_ready;
	logic                         rgb_valid;
	logic [CB-1:0]                red;
	logic [CB-1:0]                green;
	logic [CB-1:0]                blue;

	// Colours owed by the block, oldest first
	rgb_t                pending_rgb [$];
	int                  n_sent      = 0;
	int                  n_seen      = 0;
	int                  n_errors    = 0;
	logic                source_done = 1'b0;
	logic                hold_off    = 1'b0;

	// Pixel currently offered, with the colour it must turn into
	logic [hrc_pkg::HUE_W-1:0]    cur_hue;
	logic [CB-1:0]                cur_sat;
	logic [CB-1:0]                cur_bri;
	rgb_t                         cur_rgb;

	hsv_to_rgb_converter #(
		.CHANNEL_BITS(CB)
	) u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.pix_valid  (pix_valid),
		.pix_ready  (pix_ready),
		.hue        (hue),
		.saturation (saturation),
		.brightness (brightness),
		.rgb_valid  (rgb_valid),
		.rgb_ready  (rgb_ready),
		.red        (red),
		.green      (green),
		.blue       (blue)
	);

	always #2 clk = ~clk;

	// Work out the colour of one pixel in fixed point, truncating every divide
	function automatic rgb_t convert_hsv(logic [hrc_pkg::HUE_W-1:0] h, logic [CB-1:0] s,
			logic [CB-1:0] v);
		logic [2*CB-1:0]               prod;
		logic [CB-1:0]                 chroma;
		logic [CB-1:0]                 second;
		logic [CB-1:0]                 offset;
		logic [hrc_pkg::MOD_W-1:0]     hmod;
		logic [hrc_pkg::WT_W-1:0]      weight;
		logic [CB+hrc_pkg::WT_W-1:0]   scaled;
		hrc_pkg::sector_t              sector;
		rgb_t                          o;
		prod   = v * s;
		chroma = CB'(prod / FULL);
		hmod   = hrc_pkg::MOD_W'(h % 120);
		// 60 - |hmod - 60| folds to a triangle peaking at sixty
		weight = (hmod < hrc_pkg::MOD_W'(60)) ? hrc_pkg::WT_W'(hmod) :
			hrc_pkg::WT_W'(hrc_pkg::MOD_W'(120) - hmod);
		scaled = chroma * weight;
		second = CB'(scaled / 60);
		offset = v - chroma;
		if (h < hrc_pkg::DEG_60)
			sector = hrc_pkg::SEC_RED_YEL;
		else if (h < hrc_pkg::DEG_120)
			sector = hrc_pkg::SEC_YEL_GRN;
		else if (h < hrc_pkg::DEG_180)
			sector = hrc_pkg::SEC_GRN_CYN;
		else if (h < hrc_pkg::DEG_240)
			sector = hrc_pkg::SEC_CYN_BLU;
		else if (h < hrc_pkg::DEG_300)
			sector = hrc_pkg::SEC_BLU_MAG;
		else
			sector = hrc_pkg::SEC_MAG_RED;
		case (sector)
			hrc_pkg::SEC_RED_YEL: o = {chroma, second, CB'(0)};
			hrc_pkg::SEC_YEL_GRN: o = {second, chroma, CB'(0)};
			hrc_pkg::SEC_GRN_CYN: o = {CB'(0), chroma, second};
			hrc_pkg::SEC_CYN_BLU: o = {CB'(0), second, chroma};
			hrc_pkg::SEC_BLU_MAG: o = {second, CB'(0), chroma};
			default:              o = {chroma, CB'(0), second};
		endcase
		o.red   = o.red + offset;
		o.green = o.green + offset;
		o.blue  = o.blue + offset;
		return o;
	endfunction

	// Lean towards the ends of the scale now and then
	function automatic logic [CB-1:0] pick_level();
		int roll;
		roll = $urandom_range(99);
		if (roll < 10)
			return '0;
		else if (roll < 20)
			return CB'(FULL);
		else
			return CB'($urandom_range(FULL));
	endfunction

	// Load the next pixel: table rows first, then random ones
	task automatic make_pixel(input int idx);
		pix_row_t row;
		if (idx < N_DIRECTED) begin
			row     = DIRECTED_ROWS[idx];
			cur_hue = row.hue;
			cur_sat = row.sat;
			cur_bri = row.bri;
			if (row.known)
				cur_rgb = {row.red, row.green, row.blue};
			else
				cur_rgb = convert_hsv(row.hue, row.sat, row.bri);
		end else begin
			// Mostly legal hue, with a share of codes past 359
			if ($urandom_range(99) < 12)
				cur_hue = hrc_pkg::HUE_W'($urandom_range(511, 360));
			else
				cur_hue = hrc_pkg::HUE_W'($urandom_range(359));
			cur_sat = pick_level();
			cur_bri = pick_level();
			cur_rgb = convert_hsv(cur_hue, cur_sat, cur_bri);
		end
	endtask

	task automatic report_mismatch(input string what, input rgb_t got, input rgb_t want);
		if (n_errors < MAX_PRINTED)
			$display({"mismatch on result beat %0d: %s got r=%0d g=%0d b=%0d",
				" exp r=%0d g=%0d b=%0d"},
				n_seen, what, got.red, got.green, got.blue, want.red, want.green, want.blue);
		n_errors++;
	endtask

	// Hold reset at the start, then run to the end and give the verdict
	initial begin : run_control
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		wait (source_done);
		// Drain every owed colour, then allow a tail for stray beats
		while (pending_rgb.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (n_errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// Offer pixels. Valid only drops or moves on once the current beat is
	// taken; the idle share depends on which third of the run we are in.
	initial begin : pixel_source
		bit have;
		int phase;
		int idle;
		have = 1'b0;
		wait (arst_n);
		while (n_sent < N_TOTAL) begin
			@(posedge clk);
			if (pix_valid && pix_ready) begin
				pending_rgb.push_back(cur_rgb);
				n_sent++;
				have = 1'b0;
			end
			if (!pix_valid || pix_ready) begin
				phase = n_sent * 3 / N_TOTAL;
				idle  = (phase == 0) ? 23 : (phase == 1) ? 48 : 0;
				if (n_sent < N_TOTAL && $urandom_range(99) >= idle) begin
					if (!have) begin
						make_pixel(n_sent);
						have = 1'b1;
					end
					pix_valid  <= 1'b1;
					hue        <= cur_hue;
					saturation <= cur_sat;
					brightness <= cur_bri;
				end else begin
					pix_valid <= 1'b0;
				end
			end
		end
		source_done = 1'b1;
	end

	// Take result beats and compare each field with the oldest owed colour
	initial begin : rgb_sink
		rgb_t got;
		rgb_t want;
		int   phase;
		int   idle;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (rgb_valid && rgb_ready) begin
				got = {red, green, blue};
				if (pending_rgb.size() == 0) begin
					report_mismatch("unexpected beat", got, '0);
				end else begin
					want = pending_rgb.pop_front();
					if (got.red !== want.red || got.green !== want.green ||
							got.blue !== want.blue)
						report_mismatch("wrong colour", got, want);
				end
				n_seen++;
			end
			phase = n_seen * 3 / N_TOTAL;
			idle  = (phase == 0) ? 48 : (phase == 1) ? 23 : 0;
			rgb_ready <= !hold_off && ($urandom_range(99) >= idle);
		end
	end

	// Once the source runs flat out, block the result side for a long
	// stretch so the queue fills and pix_ready has to drop
	initial begin : back_pressure
		wait (n_sent >= N_TOTAL * 2 / 3 + 40);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (HOLD_OFF_CYCLES) @(posedge clk);
		hold_off <= 1'b0;
	end

	// Count cycles in which neither channel moves a beat
	initial begin : watchdog
		int quiet;
		quiet = 0;
		wait (arst_n);
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((pix_valid && pix_ready) || (rgb_valid && rgb_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("timeout: no beat moved for %0d cycles", STALL_LIMIT);
		$display("*** FAILED ***");
		$finish;
	end

endmodule
